>>> rtl/core/quaternion_to_rotation_matrix_core_assert.svh
// Assertion macros shared by the checker files of the rotation matrix core.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef QUATERNION_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_CORE_ASSERT_SVH

// The condition must never hold outside reset.
`define Q2R_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("q2r: forbidden condition seen");

// The antecedent must be followed in the same cycle by the consequent.
`define Q2R_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("q2r: implication failed");

`endif

>>> rtl/core/q2r_pkg.sv
// Shared widths, latencies and types of the quaternion to rotation matrix core.
// Depends on nothing; every module of the core imports it.
package q2r_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int IN_WIDTH   = 18;
   localparam int OUT_WIDTH  = FRAC_BITS + 2;
   localparam int PROD_WIDTH = 2 * IN_WIDTH;
   localparam int NORM_WIDTH = 2 * IN_WIDTH + 1;
   localparam int NUM_WIDTH  = 2 * IN_WIDTH + 2;
   localparam int STEPS      = FRAC_BITS + 1;
   localparam int DIV_LAT    = STEPS + 2;
   localparam int ENTRIES    = 9;
   // Two product stages, the divider and the output register.
   localparam int LATENCY    = DIV_LAT + 3;

   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   typedef logic signed [IN_WIDTH-1:0]   comp_type;
   typedef logic signed [NUM_WIDTH-1:0]  num_type;
   typedef logic        [NORM_WIDTH-1:0] norm_type;
   typedef logic signed [OUT_WIDTH-1:0]  entry_type;

   // Control that travels alongside the numerators.
   typedef struct packed {
      logic vld;
      logic zero;
   } ctl_type;

endpackage

>>> rtl/core/quaternion_to_rotation_matrix_core.sv
// Each item passes the product stages, the divider and the output register; rsp_valid
// is registered alongside the result, so it is high while the result is presented.
// Throughput: one item per cycle; the 15 quotient bit stages of the nine dividers
// each hold a different item, so a new item enters every cycle.
// busy is high only during reset; the receiver cannot stall and none is needed.
// Reset (synchronous, active high) clears the valid bits; data is not reset.
module quaternion_to_rotation_matrix_core
   import q2r_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  comp_type  req_q_w,
   input  comp_type  req_q_x,
   input  comp_type  req_q_y,
   input  comp_type  req_q_z,
   output logic      rsp_valid,
   output entry_type rsp_r0c0,
   output entry_type rsp_r0c1,
   output entry_type rsp_r0c2,
   output entry_type rsp_r1c0,
   output entry_type rsp_r1c1,
   output entry_type rsp_r1c2,
   output entry_type rsp_r2c0,
   output entry_type rsp_r2c1,
   output entry_type rsp_r2c2,
   output logic      rsp_zero_norm
);

   ctl_type          ctl;
   norm_type         n;
   num_type          num [ENTRIES];
   entry_type        q   [ENTRIES];
   logic [DIV_LAT-1:0] vld_ff;
   logic [DIV_LAT-1:0] zero_ff;
   logic             rsp_valid_ff;
   logic             rsp_zero_ff;
   entry_type        out_ff [ENTRIES];
   entry_type        out_in [ENTRIES];

   assign busy = reset;

   q2r_prod u_prod (
      .clock  (clock),
      .reset  (reset),
      .in_vld (start && !busy),
      .q_w    (req_q_w),
      .q_x    (req_q_x),
      .q_y    (req_q_y),
      .q_z    (req_q_z),
      .ctl    (ctl),
      .n      (n),
      .num    (num)
   );

   for (genvar g = 0; g < ENTRIES; g++) begin : g_div
      q2r_div u_div (
         .clock (clock),
         .num   (num[g]),
         .n     (n),
         .q     (q[g])
      );
   end

   // Valid and zero flags keep pace with the dividers.
   always_ff @(posedge clock) begin
      zero_ff <= {zero_ff[DIV_LAT-2:0], ctl.zero};
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIV_LAT-2:0], ctl.vld};
      end
   end

   // A zero norm replaces the quotients with the identity matrix.
   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         if (zero_ff[DIV_LAT-1]) begin
            out_in[k] = (k % 4 == 0) ? entry_type'(ONE) : '0;
         end else begin
            out_in[k] = q[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ENTRIES; k++) begin
         out_ff[k] <= out_in[k];
      end
      rsp_zero_ff <= zero_ff[DIV_LAT-1];
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[DIV_LAT-1];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_zero_norm = rsp_zero_ff;
   assign rsp_r0c0      = out_ff[0];
   assign rsp_r0c1      = out_ff[1];
   assign rsp_r0c2      = out_ff[2];
   assign rsp_r1c0      = out_ff[3];
   assign rsp_r1c1      = out_ff[4];
   assign rsp_r1c2      = out_ff[5];
   assign rsp_r2c0      = out_ff[6];
   assign rsp_r2c1      = out_ff[7];
   assign rsp_r2c2      = out_ff[8];

endmodule

>>> rtl/core/q2r_prod.sv
// Front end: component products, squared norm and the nine signed numerators.
// Depends on q2r_pkg.
module q2r_prod
   import q2r_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_vld,
   input  comp_type q_w,
   input  comp_type q_x,
   input  comp_type q_y,
   input  comp_type q_z,
   output ctl_type  ctl,
   output norm_type n,
   output num_type  num [ENTRIES]
);

   logic signed [PROD_WIDTH-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [PROD_WIDTH-1:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic    vld1_ff;
   ctl_type ctl_ff;
   num_type n_s;
   num_type num_in [ENTRIES];
   num_type num_ff [ENTRIES];
   num_type e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;

   // First stage: the ten distinct products.
   always_ff @(posedge clock) begin
      ww_ff <= q_w * q_w;
      xx_ff <= q_x * q_x;
      yy_ff <= q_y * q_y;
      zz_ff <= q_z * q_z;
      xy_ff <= q_x * q_y;
      wz_ff <= q_w * q_z;
      xz_ff <= q_x * q_z;
      wy_ff <= q_w * q_y;
      yz_ff <= q_y * q_z;
      wx_ff <= q_w * q_x;
   end

   always_comb begin
      e_ww = NUM_WIDTH'(ww_ff);
      e_xx = NUM_WIDTH'(xx_ff);
      e_yy = NUM_WIDTH'(yy_ff);
      e_zz = NUM_WIDTH'(zz_ff);
      e_xy = NUM_WIDTH'(xy_ff);
      e_wz = NUM_WIDTH'(wz_ff);
      e_xz = NUM_WIDTH'(xz_ff);
      e_wy = NUM_WIDTH'(wy_ff);
      e_yz = NUM_WIDTH'(yz_ff);
      e_wx = NUM_WIDTH'(wx_ff);
      n_s  = e_ww + e_xx + e_yy + e_zz;
      // Diagonal entries are N - 2(a+b); the others are 2(p +- q).
      num_in[0] = n_s - ((e_yy + e_zz) <<< 1);
      num_in[1] = (e_xy - e_wz) <<< 1;
      num_in[2] = (e_xz + e_wy) <<< 1;
      num_in[3] = (e_xy + e_wz) <<< 1;
      num_in[4] = n_s - ((e_xx + e_zz) <<< 1);
      num_in[5] = (e_yz - e_wx) <<< 1;
      num_in[6] = (e_xz - e_wy) <<< 1;
      num_in[7] = (e_yz + e_wx) <<< 1;
      num_in[8] = n_s - ((e_xx + e_yy) <<< 1);
   end

   // Second stage: norm and numerators.
   always_ff @(posedge clock) begin
      n <= n_s[NORM_WIDTH-1:0];
      for (int k = 0; k < ENTRIES; k++) begin
         num_ff[k] <= num_in[k];
      end
   end

   // Control: the zero flag follows the data, the valid bits are reset.
   always_ff @(posedge clock) begin
      ctl_ff.zero <= (n_s == '0);
      if (reset) begin
         vld1_ff    <= 1'b0;
         ctl_ff.vld <= 1'b0;
      end else begin
         vld1_ff    <= in_vld;
         ctl_ff.vld <= vld1_ff;
      end
   end

   assign ctl = ctl_ff;
   assign num = num_ff;

endmodule

>>> rtl/core/q2r_div.sv
// Pipelined restoring divider: round(num * 2^FRAC_BITS / n), saturated to +-1.0.
// Depends on q2r_pkg; one quotient bit is resolved per stage.
module q2r_div
   import q2r_pkg::*;
(
   input  logic      clock,
   input  num_type   num,
   input  norm_type  n,
   output entry_type q
);

   logic [NUM_WIDTH-1:0]  mag;
   logic [NORM_WIDTH-1:0] rem_ff [STEPS+1];
   logic [NORM_WIDTH-1:0] n_ff   [STEPS+1];
   logic [STEPS-1:0]      t_ff   [STEPS+1];
   logic                  sat_ff [STEPS+1];
   logic                  neg_ff [STEPS+1];
   logic [NORM_WIDTH-1:0] rem_in [STEPS];
   logic [STEPS-1:0]      t_in   [STEPS];
   logic [NORM_WIDTH:0]   dbl    [STEPS];
   logic                  ge     [STEPS];
   logic [STEPS:0]        rnd;
   logic [FRAC_BITS:0]    qm;
   entry_type             q_ff;

   assign mag = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);

   // Entry stage: magnitude, sign and the saturation test |num| >= N.
   always_ff @(posedge clock) begin
      n_ff[0]   <= n;
      neg_ff[0] <= num[NUM_WIDTH-1];
      sat_ff[0] <= (mag >= NUM_WIDTH'(n));
      rem_ff[0] <= (mag >= NUM_WIDTH'(n)) ? '0 : mag[NORM_WIDTH-1:0];
      t_ff[0]   <= '0;
   end

   // Each step doubles the remainder and subtracts N when it fits.
   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         dbl[k]    = {rem_ff[k], 1'b0};
         ge[k]     = (dbl[k] >= {1'b0, n_ff[k]});
         rem_in[k] = ge[k] ? NORM_WIDTH'(dbl[k] - {1'b0, n_ff[k]}) : dbl[k][NORM_WIDTH-1:0];
         t_in[k]   = {t_ff[k][STEPS-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS; k++) begin
         rem_ff[k+1] <= rem_in[k];
         t_ff[k+1]   <= t_in[k];
         n_ff[k+1]   <= n_ff[k];
         sat_ff[k+1] <= sat_ff[k];
         neg_ff[k+1] <= neg_ff[k];
      end
   end

   // Round half away from zero from one extra fraction bit, then apply the sign.
   always_comb begin
      rnd = {1'b0, t_ff[STEPS]} + (STEPS + 1)'(1);
      qm  = sat_ff[STEPS] ? ONE : rnd[STEPS:1];
   end

   always_ff @(posedge clock) begin
      q_ff <= neg_ff[STEPS] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
   end

   assign q = q_ff;

endmodule

>>> rtl/core/q2r_checker.sv
// Port-level checks of the rotation matrix core, bound to the top level.
// Depends on q2r_pkg and quaternion_to_rotation_matrix_core_assert.svh.
`include "quaternion_to_rotation_matrix_core_assert.svh"

module q2r_checker
   import q2r_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      start,
   input logic      busy,
   input comp_type  req_q_w,
   input comp_type  req_q_x,
   input comp_type  req_q_y,
   input comp_type  req_q_z,
   input logic      rsp_valid,
   input entry_type rsp_r0c0,
   input entry_type rsp_r0c1,
   input entry_type rsp_r1c1,
   input entry_type rsp_r2c2,
   input logic      rsp_zero_norm
);

   logic accepted;
   logic identity_seen;
   logic req_all_zero;

   assign accepted      = start && !busy;
   assign identity_seen = rsp_r0c0 == entry_type'(ONE) && rsp_r1c1 == entry_type'(ONE)
                          && rsp_r2c2 == entry_type'(ONE) && rsp_r0c1 == '0;
   assign req_all_zero  = req_q_w == '0 && req_q_x == '0 && req_q_y == '0 && req_q_z == '0;

   // The core never pushes back once it is out of reset.
   `Q2R_ASSERT_NEVER(a_never_busy, clock, reset, busy && !$past(reset))

   // Every result comes from an item accepted a fixed latency earlier.
   `Q2R_ASSERT_IMPLY(a_result_has_item, clock, reset, rsp_valid, $past(accepted, LATENCY))

   // A flagged result carries the identity diagonal.
   `Q2R_ASSERT_IMPLY(a_zero_identity, clock, reset, rsp_valid && rsp_zero_norm, identity_seen)

   // The flag is raised only for an all-zero quaternion.
   `Q2R_ASSERT_IMPLY(a_zero_source, clock, reset, rsp_valid && rsp_zero_norm, $past(req_all_zero, LATENCY))

endmodule

bind quaternion_to_rotation_matrix_core q2r_checker u_q2r_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_q_w       (req_q_w),
   .req_q_x       (req_q_x),
   .req_q_y       (req_q_y),
   .req_q_z       (req_q_z),
   .rsp_valid     (rsp_valid),
   .rsp_r0c0      (rsp_r0c0),
   .rsp_r0c1      (rsp_r0c1),
   .rsp_r1c1      (rsp_r1c1),
   .rsp_r2c2      (rsp_r2c2),
   .rsp_zero_norm (rsp_zero_norm)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the quaternion to rotation matrix core.
// Depends on q2r_pkg and quaternion_to_rotation_matrix_core; predicts each matrix exactly.
module testbench;
   import q2r_pkg::*;

   // One matrix as the block gives it, row-major, with the zero flag.
   typedef struct {
      entry_type entry[ENTRIES];
      logic      zero;
   } matrix_type;

   // Rounded and saturated ratio mag/n as a signed Q1.FRAC_BITS entry.
   function automatic entry_type scaled_ratio(bit neg, longint unsigned mag,
                                              longint unsigned n);
      longint unsigned q;
      q = (mag >= n) ? longint'(ONE) : ((mag << (FRAC_BITS + 1)) + n) / (2 * n);
      if (q > longint'(ONE)) q = longint'(ONE);
      return neg ? entry_type'(-q) : entry_type'(q);
   endfunction

   // Signed numerator to entry.
   function automatic entry_type signed_ratio(longint s, longint unsigned n);
      return scaled_ratio(s < 0, (s < 0) ? longint'(-s) : s, n);
   endfunction

   // Exact normalized rotation matrix of a quaternion.
   function automatic matrix_type predict_matrix(comp_type qw, comp_type qx,
                                                 comp_type qy, comp_type qz);
      matrix_type m;
      longint w, x, y, z, n;
      w = qw; x = qx; y = qy; z = qz;
      n = w*w + x*x + y*y + z*z;
      m.zero = (n == 0);
      if (m.zero) begin
         foreach (m.entry[k]) m.entry[k] = '0;
         m.entry[0] = entry_type'(ONE);
         m.entry[4] = entry_type'(ONE);
         m.entry[8] = entry_type'(ONE);
         return m;
      end
      m.entry[0] = signed_ratio(n - 2*(y*y + z*z), n);
      m.entry[1] = signed_ratio(2*(x*y - w*z), n);
      m.entry[2] = signed_ratio(2*(x*z + w*y), n);
      m.entry[3] = signed_ratio(2*(x*y + w*z), n);
      m.entry[4] = signed_ratio(n - 2*(x*x + z*z), n);
      m.entry[5] = signed_ratio(2*(y*z - w*x), n);
      m.entry[6] = signed_ratio(2*(x*z - w*y), n);
      m.entry[7] = signed_ratio(2*(y*z + w*x), n);
      m.entry[8] = signed_ratio(n - 2*(x*x + y*y), n);
      return m;
   endfunction

   // Holds the matrices still owed by the block and checks arrivals in order.
   class rotation_scoreboard;
      matrix_type expected_matrices[$];
      int         error_count;
      int         matched_count;
      int         zero_count;

      task report(string what);
         $display("ERROR at %0t: %s", $realtime, what);
         error_count++;
      endtask

      function void note_item(comp_type qw, comp_type qx, comp_type qy, comp_type qz);
         expected_matrices.push_back(predict_matrix(qw, qx, qy, qz));
      endfunction

      task check_matrix(matrix_type got);
         matrix_type want;
         bit         bad;
         if (expected_matrices.size() == 0) begin
            report("matrix with no item outstanding");
            return;
         end
         want = expected_matrices.pop_front();
         bad = 0;
         foreach (want.entry[k])
            if (got.entry[k] !== want.entry[k]) begin
               report($sformatf("entry r%0dc%0d got %0d want %0d",
                                k / 3, k % 3, got.entry[k], want.entry[k]));
               bad = 1;
            end
         if (got.zero !== want.zero) begin
            report($sformatf("zero_norm got %b want %b", got.zero, want.zero));
            bad = 1;
         end
         if (!bad) matched_count++;
         if (want.zero) zero_count++;
      endtask
   endclass

   logic      clock, reset, start, busy;
   comp_type  req_q_w, req_q_x, req_q_y, req_q_z;
   logic      rsp_valid, rsp_zero_norm;
   entry_type rsp_r0c0, rsp_r0c1, rsp_r0c2, rsp_r1c0, rsp_r1c1, rsp_r1c2;
   entry_type rsp_r2c0, rsp_r2c1, rsp_r2c2;

   rotation_scoreboard matrices = new();

   quaternion_to_rotation_matrix_core dut (.*);

   // Clock.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watch both channels on every edge.
   always @(posedge clock) begin
      matrix_type got;
      if (!reset) begin
         if (start && !busy) matrices.note_item(req_q_w, req_q_x, req_q_y, req_q_z);
         if (rsp_valid) begin
            got.entry = '{rsp_r0c0, rsp_r0c1, rsp_r0c2, rsp_r1c0, rsp_r1c1,
                          rsp_r1c2, rsp_r2c0, rsp_r2c1, rsp_r2c2};
            got.zero = rsp_zero_norm;
            matrices.check_matrix(got);
         end
      end
   end

   // Idle gap: mostly none or short, sometimes long.
   task idle_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : 1;
      if (gap != 0) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 3);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Present one item and hold it until accepted.
   task send_item(comp_type qw, comp_type qx, comp_type qy, comp_type qz, bit gaps);
      start   <= 1'b1;
      req_q_w <= qw;
      req_q_x <= qx;
      req_q_y <= qy;
      req_q_z <= qz;
      do @(posedge clock); while (busy);
      if (gaps) idle_gap();
   endtask

   // Random component: full range, small, extreme or zero.
   function automatic comp_type random_comp();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return comp_type'($urandom_range(0, 1) ? -131072 : 131071);
         2, 3:    return comp_type'($signed($urandom_range(0, 64)) - 32);
         default: return comp_type'($urandom);
      endcase
   endfunction

   // Stimulus.
   initial begin
      comp_type lo, hi;
      lo = comp_type'(-131072);
      hi = comp_type'(131071);
      start = 0; reset = 1;
      req_q_w = '0; req_q_x = '0; req_q_y = '0; req_q_z = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero quaternion, extremes, axis-aligned and tie cases.
      send_item('0, '0, '0, '0, 0);
      send_item(hi, hi, hi, hi, 0);
      send_item(lo, lo, lo, lo, 0);
      send_item(lo, hi, lo, hi, 0);
      send_item(hi, '0, '0, '0, 0);
      send_item('0, lo, '0, '0, 0);
      send_item('0, '0, hi, '0, 0);
      send_item('0, '0, '0, lo, 0);
      send_item(16384, 0, 0, 0, 1);
      send_item(1, 1, 0, 0, 0);
      send_item(-1, 1, 1, 1, 0);
      send_item(1, 0, 0, 0, 0);
      send_item(0, 0, 0, -1, 0);
      send_item(3, 1, 1, 1, 1);
      send_item(lo, '0, '0, hi, 0);
      send_item(11585, 11585, 0, 0, 0);
      send_item(1, 2, 3, 4, 0);
      send_item(-7, 5, -3, 1, 1);

      // Hold off until everything owed has arrived.
      start <= 1'b0;
      while (matrices.expected_matrices.size() != 0) @(posedge clock);

      // Random items, with stretches of back-to-back traffic.
      for (int i = 0; i < 700; i++)
         send_item(random_comp(), random_comp(), random_comp(), random_comp(),
                   (i / 100) % 3 != 1);
      start <= 1'b0;

      while (matrices.expected_matrices.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      $display("Checked %0d matrices, %0d of them from zero quaternions.",
               matrices.matched_count + matrices.error_count, matrices.zero_count);
      $display("Mismatches: %0d.", matrices.error_count);
      if (matrices.error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("Timed out with %0d matrices outstanding.",
               matrices.expected_matrices.size());
      $display("testbench: done, errors");
      $finish;
   end

endmodule
